// ----- sv/dkic_pkg.sv -----
// Shared types and constants of the double-knock interval classifier.
`timescale 1ns / 1ps

package dkic_pkg;

    localparam int IN_BITS    = 80;
    localparam int OUT_BITS   = 40;
    localparam int CFG_BITS   = 16;
    localparam int IDX_BITS   = 3;
    localparam int THR_BITS   = 15;
    localparam int THR2_BITS  = 30;
    localparam int SQ_BITS    = 31;
    localparam int MAG_BITS   = 32;
    localparam int STAMP_BITS = 32;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    localparam logic [THR_BITS-1:0] THR_RESET      = 15'd3456;
    localparam logic [15:0]         MIN_GAP_RESET  = 16'd200;
    localparam logic [15:0]         FAST_RESET     = 16'd500;
    localparam logic [15:0]         SLOW_RESET     = 16'd1200;
    localparam logic [15:0]         TIMEOUT_RESET  = 16'd2000;
    localparam logic [15:0]         COOLDOWN_RESET = 16'd2000;

    typedef enum logic [IDX_BITS-1:0] {
        REG_THRESHOLD = 3'd0,
        REG_MIN_GAP   = 3'd1,
        REG_FAST      = 3'd2,
        REG_SLOW      = 3'd3,
        REG_TIMEOUT   = 3'd4,
        REG_COOLDOWN  = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        CLS_FAST   = 2'd0,
        CLS_MEDIUM = 2'd1,
        CLS_SLOW   = 2'd2
    } t_class;

    // Timing registers used by the back end.
    typedef struct packed {
        logic [15:0] min_gap;
        logic [15:0] fast_limit;
        logic [15:0] slow_limit;
        logic [15:0] timeout;
        logic [15:0] cooldown;
    } t_cfg;

    // One classified sample on its way to the back end.
    typedef struct packed {
        logic                  knock;
        logic [STAMP_BITS-1:0] now;
    } t_qword;

endpackage

// ----- sv/double_knock_interval_classifier.sv -----
// Top level of the double-knock interval classifier.
//
// Input stream s_axis: one word per timestamped acceleration sample. A sample
// whose squared magnitude exceeds the squared threshold is a knock; a second
// knock more than min_gap_ms after the first yields one output word on
// m_axis with the interval class and the interval, then a cooldown begins.
// Samples that cause no result produce no output word.
// A result passes through two squaring/compare stages, the queue and the
// output register. Throughput: one sample per cycle while s_axis_tready is
// high; the back end updates its state as each word is taken, the queue lets
// the squaring pipeline keep running while the receiver stalls, and
// s_axis_tready drops only once the queue is full. Reset (synchronous, active
// low) clears the pipeline, the queue, the armed/cooldown state and loads
// default register values. Registers are written through i_cfg_we/i_cfg_idx/
// i_cfg_data by the user only while idle; the block does not enforce it.
`timescale 1ns / 1ps

module double_knock_interval_classifier #(
    parameter int TIME_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // accel_x[15:0], accel_y[31:16], accel_z[47:32], now_ms[79:48]
    input  logic [dkic_pkg::IN_BITS-1:0]          s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // knock_class[1:0], interval_ms[33:2], zero pad[39:34]
    output logic [dkic_pkg::OUT_BITS-1:0]         m_axis_tdata,
    input  logic                                  i_cfg_we,
    input  logic [dkic_pkg::IDX_BITS-1:0]         i_cfg_idx,
    input  logic [dkic_pkg::CFG_BITS-1:0]         i_cfg_data
);

    logic [dkic_pkg::THR_BITS-1:0]  r_thr;
    logic [dkic_pkg::THR2_BITS-1:0] r_thr2;
    dkic_pkg::t_cfg                 r_cfg;

    logic             w_fq_valid, w_fq_ready, w_qb_valid, w_qb_ready;
    dkic_pkg::t_qword w_fq_word, w_qb_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr            <= dkic_pkg::THR_RESET;
            r_cfg.min_gap    <= dkic_pkg::MIN_GAP_RESET;
            r_cfg.fast_limit <= dkic_pkg::FAST_RESET;
            r_cfg.slow_limit <= dkic_pkg::SLOW_RESET;
            r_cfg.timeout    <= dkic_pkg::TIMEOUT_RESET;
            r_cfg.cooldown   <= dkic_pkg::COOLDOWN_RESET;
        end else if (i_cfg_we) begin
            unique case (dkic_pkg::t_reg_idx'(i_cfg_idx))
                dkic_pkg::REG_THRESHOLD: r_thr            <= i_cfg_data[14:0];
                dkic_pkg::REG_MIN_GAP:   r_cfg.min_gap    <= i_cfg_data;
                dkic_pkg::REG_FAST:      r_cfg.fast_limit <= i_cfg_data;
                dkic_pkg::REG_SLOW:      r_cfg.slow_limit <= i_cfg_data;
                dkic_pkg::REG_TIMEOUT:   r_cfg.timeout    <= i_cfg_data;
                dkic_pkg::REG_COOLDOWN:  r_cfg.cooldown   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // squared threshold, taken from the register in the next cycle
    always_ff @(posedge i_clk) begin
        r_thr2 <= dkic_pkg::THR2_BITS'(r_thr) * dkic_pkg::THR2_BITS'(r_thr);
    end

    dkic_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_thr2  (r_thr2),
        .o_valid (w_fq_valid),
        .i_ready (w_fq_ready),
        .o_word  (w_fq_word)
    );

    dkic_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fq_valid),
        .o_ready (w_fq_ready),
        .i_word  (w_fq_word),
        .o_valid (w_qb_valid),
        .i_ready (w_qb_ready),
        .o_word  (w_qb_word)
    );

    dkic_back #(
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qb_valid),
        .o_ready (w_qb_ready),
        .i_word  (w_qb_word),
        .i_cfg   (r_cfg),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

// ----- sv/dkic_front.sv -----
// Front end: squares the three axes, sums and compares against the squared threshold.
`timescale 1ns / 1ps

module dkic_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [dkic_pkg::IN_BITS-1:0]  i_data,
    input  logic [dkic_pkg::THR2_BITS-1:0] i_thr2,
    output logic                          o_valid,
    input  logic                          i_ready,
    output dkic_pkg::t_qword              o_word
);

    logic                              r_v1;
    logic [dkic_pkg::SQ_BITS-1:0]      r_sx, r_sy, r_sz;
    logic [dkic_pkg::STAMP_BITS-1:0]   r_now1;
    logic                              r_v2;
    dkic_pkg::t_qword                  r_word;
    logic                              w_adv1, w_adv2;
    logic signed [15:0]                w_x, w_y, w_z;
    logic signed [31:0]                w_px, w_py, w_pz;
    logic [dkic_pkg::MAG_BITS-1:0]     w_mag2;

    assign w_x = i_data[15:0];
    assign w_y = i_data[31:16];
    assign w_z = i_data[47:32];
    assign w_px = w_x * w_x;
    assign w_py = w_y * w_y;
    assign w_pz = w_z * w_z;

    assign w_adv2  = !r_v2 || i_ready;
    assign w_adv1  = !r_v1 || w_adv2;
    assign o_ready = w_adv1;

    assign w_mag2 = dkic_pkg::MAG_BITS'(r_sx) + dkic_pkg::MAG_BITS'(r_sy)
                  + dkic_pkg::MAG_BITS'(r_sz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= i_valid;
            if (w_adv2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1 && i_valid) begin
            r_sx   <= dkic_pkg::SQ_BITS'(w_px);
            r_sy   <= dkic_pkg::SQ_BITS'(w_py);
            r_sz   <= dkic_pkg::SQ_BITS'(w_pz);
            r_now1 <= i_data[79:48];
        end
        if (w_adv2 && r_v1) begin
            r_word.knock <= w_mag2 > dkic_pkg::MAG_BITS'(i_thr2);
            r_word.now   <= r_now1;
        end
    end

    assign o_valid = r_v2;
    assign o_word  = r_word;

endmodule

// ----- sv/dkic_queue.sv -----
// Short queue between the front and back ends.
`timescale 1ns / 1ps

module dkic_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  dkic_pkg::t_qword i_word,
    output logic             o_valid,
    input  logic             i_ready,
    output dkic_pkg::t_qword o_word
);

    dkic_pkg::t_qword                    r_mem [dkic_pkg::Q_DEPTH];
    logic [dkic_pkg::Q_PTR_BITS-1:0]     r_wr, r_rd;
    logic [dkic_pkg::Q_CNT_BITS-1:0]     r_cnt;
    logic                                w_push, w_pop;

    assign o_ready = r_cnt != dkic_pkg::Q_CNT_BITS'(dkic_pkg::Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_word  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            if (w_push && !w_pop)      r_cnt <= r_cnt + 1'b1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_word;
    end

endmodule

// ----- sv/dkic_back.sv -----
// Back end: cooldown, arming, timeout, interval classification and the output register.
`timescale 1ns / 1ps

module dkic_back #(
    parameter int TIME_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  dkic_pkg::t_qword               i_word,
    input  dkic_pkg::t_cfg                 i_cfg,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [dkic_pkg::OUT_BITS-1:0]  o_data
);

    logic                  r_waiting, n_waiting;
    logic                  r_cooling, n_cooling;
    logic [TIME_BITS-1:0]  r_first, n_first;
    logic [TIME_BITS-1:0]  r_cool_start, n_cool_start;
    logic                  r_out_v;
    dkic_pkg::t_class      r_cls;
    logic [31:0]           r_interval;

    logic [TIME_BITS-1:0]  w_now, w_gap, w_cool_el;
    logic                  w_pop, w_ignore, w_classify, w_arm, w_timeout;
    dkic_pkg::t_class      w_cls;

    assign o_ready = !r_out_v || i_ready;
    assign w_pop   = i_valid && o_ready;

    always_comb begin
        w_now     = TIME_BITS'(i_word.now);
        w_gap     = w_now - r_first;
        w_cool_el = w_now - r_cool_start;
        w_ignore  = r_cooling && (w_cool_el < TIME_BITS'(i_cfg.cooldown));
        w_classify = !w_ignore && i_word.knock && r_waiting
                   && (w_gap > TIME_BITS'(i_cfg.min_gap));
        w_arm     = !w_ignore && i_word.knock && !r_waiting;
        // a freshly armed knock has zero elapsed time, so only an old arm can expire
        w_timeout = !w_ignore && r_waiting && !w_classify
                  && (w_gap > TIME_BITS'(i_cfg.timeout));

        if (w_gap < TIME_BITS'(i_cfg.fast_limit))      w_cls = dkic_pkg::CLS_FAST;
        else if (w_gap < TIME_BITS'(i_cfg.slow_limit)) w_cls = dkic_pkg::CLS_MEDIUM;
        else                                           w_cls = dkic_pkg::CLS_SLOW;

        n_cooling    = w_ignore ? r_cooling : w_classify;
        n_waiting    = w_ignore ? r_waiting
                                : (w_arm || (r_waiting && !w_classify && !w_timeout));
        n_first      = w_arm ? w_now : r_first;
        n_cool_start = w_classify ? w_now : r_cool_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting    <= 1'b0;
            r_cooling    <= 1'b0;
            r_first      <= '0;
            r_cool_start <= '0;
            r_out_v      <= 1'b0;
        end else begin
            if (w_pop) begin
                r_waiting    <= n_waiting;
                r_cooling    <= n_cooling;
                r_first      <= n_first;
                r_cool_start <= n_cool_start;
            end
            if (w_pop && w_classify) r_out_v <= 1'b1;
            else if (i_ready)        r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && w_classify) begin
            r_cls      <= w_cls;
            r_interval <= 32'(w_gap);
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = {6'd0, r_interval, r_cls};

endmodule

// ----- sv/dkic_chk.sv -----
// Port-level checker for the double-knock interval classifier, with its bind.
`timescale 1ns / 1ps

module dkic_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [dkic_pkg::OUT_BITS-1:0] m_axis_tdata
);

    // a stalled result word must hold
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_class_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("undefined knock class");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:34] == 6'd0)
        else $error("pad bits of result word not zero");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid right after reset");

    // the squaring stages, the queue and the output register lie between a sample and its result
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) ##0 !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result word too soon after reset");

endmodule

bind double_knock_interval_classifier dkic_chk u_dkic_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- dv/tb_double_knock_interval_classifier.sv -----
// Self-checking stream testbench for the double-knock interval classifier.
`timescale 1ns / 1ps

module tb_double_knock_interval_classifier;
    import dkic_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 150;
    localparam int IDLE_MAX     = 15;
    localparam int PRINT_MAX    = 40;

    localparam logic [IDX_BITS-1:0] REG_UNMAPPED    = 3'd6;
    localparam logic [IDX_BITS-1:0] REG_UNMAPPED_HI = 3'd7;

    typedef enum {SAMPLE_QUIET, SAMPLE_KNOCK, SAMPLE_NOISE} sample_kind_t;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [31:0]        stamp;
    } accel_sample_t;

    typedef struct {
        t_class      cls;
        logic [31:0] interval;
    } knock_result_t;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // accel_x[15:0], accel_y[31:16], accel_z[47:32], now_ms[79:48]
    logic [IN_BITS-1:0]  s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // knock_class[1:0], interval_ms[33:2], zero pad[39:34]
    logic [OUT_BITS-1:0] m_axis_tdata;
    logic                i_cfg_we      = 1'b0;
    logic [IDX_BITS-1:0] i_cfg_idx     = '0;
    logic [CFG_BITS-1:0] i_cfg_data    = '0;

    // Predictor copy of the registers and the detector state
    logic [THR_BITS-1:0] thr_cfg;
    logic [15:0]         gap_cfg;
    logic [15:0]         fast_cfg;
    logic [15:0]         slow_cfg;
    logic [15:0]         timeout_cfg;
    logic [15:0]         cooldown_cfg;
    logic                armed;
    logic [31:0]         first_stamp;
    logic                cooling;
    logic [31:0]         cool_start;

    accel_sample_t pending_samples[$];
    knock_result_t expected_doubles[$];
    accel_sample_t cur_sample;
    knock_result_t oldest_result;

    logic [31:0] clock_ms;
    int          queued;
    int          mismatches;
    int          cycle_count;
    int          tx_idle_max;
    int          rx_idle_max;
    int          tx_wait;
    logic        tx_next_valid;
    int          rx_wait;
    int          rx_hold_left;
    int          rx_hold_seq;
    int          rx_hold_seen;
    logic        rx_next_ready;

    double_knock_interval_classifier dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_MAX) begin
            $display("mismatch at %0t ns: %s", $time, what);
        end
    endtask

    // Advance the detector by one accepted word and queue any result it yields.
    task automatic classify_knock(input accel_sample_t s);
        longint        mag2;
        longint        thr2;
        logic [31:0]   span;
        knock_result_t res;
        mag2 = longint'(s.x) * longint'(s.x) + longint'(s.y) * longint'(s.y)
             + longint'(s.z) * longint'(s.z);
        thr2 = longint'(thr_cfg) * longint'(thr_cfg);
        if (cooling) begin
            span = s.stamp - cool_start;
            if (span < cooldown_cfg) return;
            cooling = 1'b0;
        end
        if (mag2 > thr2) begin
            if (!armed) begin
                first_stamp = s.stamp;
                armed       = 1'b1;
            end else begin
                span = s.stamp - first_stamp;
                if (span > gap_cfg) begin
                    if (span < fast_cfg) res.cls = CLS_FAST;
                    else if (span < slow_cfg) res.cls = CLS_MEDIUM;
                    else res.cls = CLS_SLOW;
                    res.interval = span;
                    expected_doubles.push_back(res);
                    armed      = 1'b0;
                    cooling    = 1'b1;
                    cool_start = s.stamp;
                end
            end
        end
        // knock test first, so a late second knock is still classified
        span = s.stamp - first_stamp;
        if (armed && span > timeout_cfg) armed = 1'b0;
    endtask

    function automatic int draw_wait(input int max_wait);
        if (max_wait == 0 || $urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, max_wait);
    endfunction

    // Sender: present one word at a time, idle a drawn number of cycles after each
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_wait = 0;
        end else begin
            tx_next_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                classify_knock(cur_sample);
                tx_wait       = draw_wait(tx_idle_max);
                tx_next_valid = 1'b0;
            end
            if (!tx_next_valid) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                end else if (pending_samples.size() != 0) begin
                    cur_sample    = pending_samples.pop_front();
                    s_axis_tdata <= {cur_sample.stamp, cur_sample.z, cur_sample.y, cur_sample.x};
                    tx_next_valid = 1'b1;
                end
            end
            s_axis_tvalid <= tx_next_valid;
        end
    end

    // Receiver: stall for a drawn wait after each word, and hold off entirely when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait      = 0;
            rx_hold_left = 0;
            rx_hold_seen = 0;
        end else begin
            if (rx_hold_seq != rx_hold_seen) begin
                rx_hold_seen = rx_hold_seq;
                rx_hold_left = HOLD_CYCLES;
            end
            if (m_axis_tvalid && m_axis_tready) rx_wait = draw_wait(rx_idle_max);
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                rx_next_ready = 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                rx_next_ready = 1'b0;
            end else begin
                rx_next_ready = 1'b1;
            end
            m_axis_tready <= rx_next_ready;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_doubles.size() == 0) begin
                report_mismatch($sformatf("unexpected result word %h", m_axis_tdata));
            end else begin
                oldest_result = expected_doubles.pop_front();
                if (m_axis_tdata[1:0] !== oldest_result.cls) begin
                    report_mismatch($sformatf("knock_class got %0d want %0d",
                                              m_axis_tdata[1:0], oldest_result.cls));
                end
                if (m_axis_tdata[33:2] !== oldest_result.interval) begin
                    report_mismatch($sformatf("interval_ms got %0d want %0d",
                                              m_axis_tdata[33:2], oldest_result.interval));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic signed [15:0] quiet_axis();
        int lim;
        lim = int'(thr_cfg) / 2;
        return 16'(int'($urandom_range(0, 2 * lim)) - lim);
    endfunction

    function automatic logic signed [15:0] loud_axis();
        int mag;
        mag = $urandom_range(int'(thr_cfg) + 1, 32768);
        if (mag == 32768 || $urandom_range(0, 1) == 0) return 16'(-mag);
        return 16'(mag);
    endfunction

    function automatic accel_sample_t make_sample(input sample_kind_t kind,
                                                  input logic [31:0] t);
        accel_sample_t s;
        int            axis;
        axis    = $urandom_range(0, 2);
        s.stamp = t;
        s.x     = quiet_axis();
        s.y     = quiet_axis();
        s.z     = quiet_axis();
        if (kind == SAMPLE_KNOCK) begin
            case (axis)
                0: s.x = loud_axis();
                1: s.y = loud_axis();
                default: s.z = loud_axis();
            endcase
        end else if (kind == SAMPLE_NOISE) begin
            s.x = 16'($urandom);
            s.y = 16'($urandom);
            s.z = 16'($urandom);
        end
        return s;
    endfunction

    task automatic queue_sample(input sample_kind_t kind, input logic [31:0] t);
        pending_samples.push_back(make_sample(kind, t));
        queued++;
    endtask

    task automatic queue_raw(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z, input logic [31:0] t);
        accel_sample_t s;
        s.x     = x;
        s.y     = y;
        s.z     = z;
        s.stamp = t;
        pending_samples.push_back(s);
    endtask

    // Noise, or one knock pair mostly at a register boundary, then a cooldown probe.
    task automatic queue_episode();
        logic [31:0] t0;
        logic [31:0] span;
        int          fill;
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(0, 3) == 0) clock_ms = $urandom;
                else clock_ms += $urandom_range(0, 3000);
                queue_sample(SAMPLE_NOISE, clock_ms);
            end
            return;
        end
        if ($urandom_range(0, 15) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 4000);
        repeat ($urandom_range(0, 2)) begin
            clock_ms += $urandom_range(0, 40);
            queue_sample(SAMPLE_QUIET, clock_ms);
        end
        clock_ms += $urandom_range(0, 40);
        t0 = clock_ms;
        queue_sample(SAMPLE_KNOCK, t0);
        case ($urandom_range(0, 9))
            0: span = gap_cfg;
            1: span = gap_cfg + 1;
            2: span = fast_cfg - 1;
            3: span = fast_cfg;
            4: span = slow_cfg - 1;
            5: span = slow_cfg;
            6: span = timeout_cfg;
            7: span = timeout_cfg + 1;
            8: span = $urandom_range(0, 3000);
            default: span = $urandom_range(0, 70000);
        endcase
        fill = $urandom_range(0, 3);
        for (int k = 1; k <= fill; k++) begin
            queue_sample(SAMPLE_QUIET, t0 + span * k / (fill + 1));
        end
        clock_ms = t0 + span;
        // drop the second knock now and then
        queue_sample($urandom_range(0, 7) == 0 ? SAMPLE_QUIET : SAMPLE_KNOCK, clock_ms);
        case ($urandom_range(0, 3))
            0: clock_ms += cooldown_cfg - 1;
            1: clock_ms += cooldown_cfg;
            default: clock_ms += $urandom_range(0, 2500);
        endcase
        queue_sample($urandom_range(0, 1) ? SAMPLE_KNOCK : SAMPLE_QUIET, clock_ms);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_samples.size() != 0 || s_axis_tvalid || expected_doubles.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(input int n, input int tx_max, input int rx_max);
        tx_idle_max = tx_max;
        rx_idle_max = rx_max;
        queued      = 0;
        while (queued < n) queue_episode();
        wait_drained();
    endtask

    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_THRESHOLD: thr_cfg      = val[THR_BITS-1:0];
            REG_MIN_GAP:   gap_cfg      = val;
            REG_FAST:      fast_cfg     = val;
            REG_SLOW:      slow_cfg     = val;
            REG_TIMEOUT:   timeout_cfg  = val;
            REG_COOLDOWN:  cooldown_cfg = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] thr, input logic [15:0] gap,
                              input logic [15:0] fast, input logic [15:0] slow,
                              input logic [15:0] tmo, input logic [15:0] cool);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_MIN_GAP, gap);
        write_reg(REG_FAST, fast);
        write_reg(REG_SLOW, slow);
        write_reg(REG_TIMEOUT, tmo);
        write_reg(REG_COOLDOWN, cool);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_config();
        set_config($urandom_range(0, 32767), $urandom_range(0, 600), $urandom_range(0, 1500),
                   $urandom_range(0, 2500), $urandom_range(0, 4000), $urandom_range(0, 3000));
    endtask

    initial begin
        thr_cfg      = THR_RESET;
        gap_cfg      = MIN_GAP_RESET;
        fast_cfg     = FAST_RESET;
        slow_cfg     = SLOW_RESET;
        timeout_cfg  = TIMEOUT_RESET;
        cooldown_cfg = COOLDOWN_RESET;
        armed        = 1'b0;
        first_stamp  = '0;
        cooling      = 1'b0;
        cool_start   = '0;
        clock_ms     = '0;
        mismatches   = 0;
        cycle_count  = 0;
        rx_hold_seq  = 0;
        tx_idle_max  = IDLE_MAX;
        rx_idle_max  = IDLE_MAX;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk through the reset settings
        queue_raw(0, 0, 0, 0);
        queue_raw(3456, 0, 0, 10);                          // exactly at threshold
        queue_raw(-32768, 32767, -32768, 100);              // arm
        queue_raw(3457, 0, 0, 300);                         // gap equal to min gap
        queue_raw(0, 0, 3457, 301);                         // fast
        queue_raw(-32768, -32768, -32768, 2300);            // inside cooldown
        queue_raw(0, -3457, 0, 2301);                       // cooldown just over, arm
        queue_raw(32767, 32767, 32767, 2801);               // interval at fast limit
        queue_raw(0, 0, -20000, 4801);
        queue_raw(20000, 0, 0, 6001);                       // interval at slow limit
        queue_raw(0, 20000, 0, 8001);
        queue_raw(100, -100, 50, 10002);                    // timeout disarms
        queue_raw(0, 0, 20000, 10003);
        queue_raw(0, 0, 0, 12003);                          // timeout boundary, stay armed
        queue_raw(20000, 0, 0, 13003);                      // late knock still classified
        queue_raw(-20000, 0, 0, 32'hFFFF_FF00);
        queue_raw(0, -20000, 0, 32'h0000_0100);             // interval across the wrap
        queue_raw(0, 0, 0, 32'h0000_08D0);
        queue_raw(1, -1, 1, 32'hFFFF_FFFF);
        queue_raw(-3457, 0, 0, 32'hFFFF_FFFF);
        queue_raw(0, 3456, 0, 32'h0000_00C8);
        queue_raw(2500, 2500, 0, 32'h0000_00C9);
        wait_drained();

        run_phase(200, IDLE_MAX, IDLE_MAX);
        set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_phase(200, IDLE_MAX, 0);
        // upper bit of the threshold write is dropped
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(200, 0, IDLE_MAX);
        // limits out of order, timeout shorter than the gap
        set_config(16'd1000, 16'd50, 16'd300, 16'd100, 16'd40, 16'd10);
        run_phase(200, IDLE_MAX, IDLE_MAX);

        // Back-to-back knock pairs against a receiver that holds off
        set_config(THR_RESET, 16'd0, FAST_RESET, SLOW_RESET, 16'hFFFF, 16'd0);
        @(negedge i_clk);
        tx_idle_max = 0;
        rx_idle_max = 0;
        rx_hold_seq++;
        repeat (80) begin
            clock_ms += 1;
            queue_sample(SAMPLE_KNOCK, clock_ms);
        end
        wait_drained();

        write_reg(REG_UNMAPPED, 16'($urandom));
        write_reg(REG_UNMAPPED_HI, 16'($urandom));
        random_config();
        run_phase(250, IDLE_MAX, IDLE_MAX);
        repeat (3) begin
            random_config();
            run_phase(200, IDLE_MAX * $urandom_range(0, 1), IDLE_MAX * $urandom_range(0, 1));
        end

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
